// ----- sv/tch_pkg.sv -----
// Shared constants and the arctangent table for the tilt-compensated heading block.
// No dependencies; every other file of the block but tch_delay imports this package.
package tch_pkg;

  localparam int SQ_W     = 32;  // sum of two 16-bit squares
  localparam int RT_W     = 16;  // integer square root of SQ_W bits
  localparam int ANG_W    = 18;  // angle, 65536 = one turn, with headroom
  localparam int ATAN_LEN = 24;

  // CORDIC gain 0.6072529 in Q2.30
  localparam logic signed [33:0] COS_GAIN = 34'sd652032874;

  function automatic logic signed [ANG_W-1:0] atan_tab(input int unsigned idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:       v = 18'sd8192;
      1:       v = 18'sd4836;
      2:       v = 18'sd2555;
      3:       v = 18'sd1297;
      4:       v = 18'sd651;
      5:       v = 18'sd326;
      6:       v = 18'sd163;
      7:       v = 18'sd81;
      8:       v = 18'sd41;
      9:       v = 18'sd20;
      10:      v = 18'sd10;
      11:      v = 18'sd5;
      12:      v = 18'sd3;
      13:      v = 18'sd1;
      14:      v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/tilt_compensated_heading_top.sv -----
// Tilt-compensated compass heading: top level of the fully pipelined datapath.
// Depends on tch_pkg, tch_isqrt_cell, tch_vec_cell, tch_rot_cell and tch_delay.
//
// Usage:
//   Drive the six raw axes and pulse start; a transaction is taken at every
//   rising edge with start high and busy low. busy stays low, so a new sample
//   set may enter in every cycle.
//   The heading appears on heading_centideg_o with done_o high for exactly one
//   cycle; results leave in the order the samples entered. The chain holds
//   one squaring stage, 16-cell square roots, a registered input to the
//   parallel vectoring chains for pitch and roll, parallel rotation chains
//   for their sine and cosine, five stages for the rotation of the magnetic
//   vector and its turn into the right half-plane, a second vectoring chain
//   for the heading and two stages for the scaling to hundredths of a degree.
//   Throughput is one transaction per cycle.
//   The receiver cannot stall: each result is valid only in its strobe cycle.
//   Reset clears every valid bit in the chain, so no stray done_o follows;
//   samples in flight at reset are dropped.
module tilt_compensated_heading_top import tch_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] mag_x_i,
  input  logic signed [15:0] mag_y_i,
  input  logic signed [15:0] mag_z_i,
  output logic               done_o,
  output logic signed [15:0] heading_centideg_o
);

  localparam int N  = CORDIC_STAGES;
  localparam int AW = 34;  // pitch/roll and sine/cosine datapath
  localparam int HW = 36;  // heading datapath

  function automatic logic signed [15:0] q15_sat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    logic signed [15:0]   o;
    r = (v + AW'(16384)) >>> 15;
    if (r > AW'(32767))       o = 16'sh7fff;
    else if (r < -AW'(32768)) o = 16'sh8000;
    else                      o = r[15:0];
    return o;
  endfunction

  assign busy = 1'b0;

  // ---------------- squares ----------------
  logic signed [31:0] axx, ayy, azz;
  logic [SQ_W-1:0]    sqp_q, sqr_q;
  logic               s1_vld_q;
  logic [79:0]        s1_side_q;

  assign axx = accel_x_i * accel_x_i;
  assign ayy = accel_y_i * accel_y_i;
  assign azz = accel_z_i * accel_z_i;

  always_ff @(posedge clk_i) begin
    sqp_q     <= $unsigned(ayy) + $unsigned(azz);
    sqr_q     <= $unsigned(axx) + $unsigned(azz);
    s1_side_q <= {accel_x_i, accel_y_i, mag_x_i, mag_y_i, mag_z_i};
  end

  // ---------------- square roots ----------------
  logic [SQ_W-1:0] pr_rem [RT_W+1];
  logic [RT_W-1:0] pr_rt  [RT_W+1];
  logic [SQ_W-1:0] rr_rem [RT_W+1];
  logic [RT_W-1:0] rr_rt  [RT_W+1];

  assign pr_rem[0] = sqp_q;
  assign pr_rt[0]  = '0;
  assign rr_rem[0] = sqr_q;
  assign rr_rt[0]  = '0;

  for (genvar j = 0; j < RT_W; j++) begin : g_sqrt
    tch_isqrt_cell #(.K(RT_W - 1 - j)) u_p (
      .clk_i (clk_i),
      .rem_i (pr_rem[j]), .root_i (pr_rt[j]),
      .rem_o (pr_rem[j+1]), .root_o (pr_rt[j+1])
    );
    tch_isqrt_cell #(.K(RT_W - 1 - j)) u_r (
      .clk_i (clk_i),
      .rem_i (rr_rem[j]), .root_i (rr_rt[j]),
      .rem_o (rr_rem[j+1]), .root_o (rr_rt[j+1])
    );
  end

  logic        d1_vld;
  logic [79:0] d1_side;

  tch_delay #(.W(80), .DEPTH(RT_W)) u_d1 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (s1_vld_q), .data_i (s1_side_q),
    .valid_o (d1_vld), .data_o (d1_side)
  );

  // ---------------- pitch / roll vectoring ----------------
  logic signed [15:0] d1_ax, d1_ay;
  logic [47:0]        d1_mag;
  logic               pre_vld_q, pz_q, rz_q;
  logic [47:0]        pre_mag_q;
  logic signed [AW-1:0] px [N+1];
  logic signed [AW-1:0] py [N+1];
  logic signed [ANG_W-1:0] pzz [N+1];
  logic signed [AW-1:0] rx [N+1];
  logic signed [AW-1:0] ry [N+1];
  logic signed [ANG_W-1:0] rzz [N+1];
  logic signed [AW-1:0] px0_q, py0_q, rx0_q, ry0_q;

  assign d1_ax  = d1_side[79:64];
  assign d1_ay  = d1_side[63:48];
  assign d1_mag = d1_side[47:0];

  always_ff @(posedge clk_i) begin
    px0_q     <= {4'b0, pr_rt[RT_W], 14'b0};
    py0_q     <= {{4{d1_ax[15]}}, d1_ax, 14'b0};
    rx0_q     <= {4'b0, rr_rt[RT_W], 14'b0};
    ry0_q     <= {{4{d1_ay[15]}}, d1_ay, 14'b0};
    pz_q      <= (pr_rt[RT_W] == '0) && (d1_ax == '0);
    rz_q      <= (rr_rt[RT_W] == '0) && (d1_ay == '0);
    pre_mag_q <= d1_mag;
  end

  assign px[0]  = px0_q;
  assign py[0]  = py0_q;
  assign pzz[0] = '0;
  assign rx[0]  = rx0_q;
  assign ry[0]  = ry0_q;
  assign rzz[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_vec_pr
    tch_vec_cell #(.W(AW), .I(i)) u_p (
      .clk_i (clk_i),
      .x_i (px[i]), .y_i (py[i]), .z_i (pzz[i]),
      .x_o (px[i+1]), .y_o (py[i+1]), .z_o (pzz[i+1])
    );
    tch_vec_cell #(.W(AW), .I(i)) u_r (
      .clk_i (clk_i),
      .x_i (rx[i]), .y_i (ry[i]), .z_i (rzz[i]),
      .x_o (rx[i+1]), .y_o (ry[i+1]), .z_o (rzz[i+1])
    );
  end

  logic        d2_vld;
  logic [49:0] d2_side;

  tch_delay #(.W(50), .DEPTH(N)) u_d2 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (pre_vld_q), .data_i ({pz_q, rz_q, pre_mag_q}),
    .valid_o (d2_vld), .data_o (d2_side)
  );

  // ---------------- sine / cosine ----------------
  logic signed [AW-1:0]    cpx [N+1];
  logic signed [AW-1:0]    cpy [N+1];
  logic signed [ANG_W-1:0] cpz [N+1];
  logic signed [AW-1:0]    crx [N+1];
  logic signed [AW-1:0]    cry [N+1];
  logic signed [ANG_W-1:0] crz [N+1];

  // a zero vector has angle zero
  assign cpx[0] = COS_GAIN;
  assign cpy[0] = '0;
  assign cpz[0] = d2_side[49] ? '0 : pzz[N];
  assign crx[0] = COS_GAIN;
  assign cry[0] = '0;
  assign crz[0] = d2_side[48] ? '0 : rzz[N];

  for (genvar i = 0; i < N; i++) begin : g_rot
    tch_rot_cell #(.W(AW), .I(i)) u_p (
      .clk_i (clk_i),
      .x_i (cpx[i]), .y_i (cpy[i]), .z_i (cpz[i]),
      .x_o (cpx[i+1]), .y_o (cpy[i+1]), .z_o (cpz[i+1])
    );
    tch_rot_cell #(.W(AW), .I(i)) u_r (
      .clk_i (clk_i),
      .x_i (crx[i]), .y_i (cry[i]), .z_i (crz[i]),
      .x_o (crx[i+1]), .y_o (cry[i+1]), .z_o (crz[i+1])
    );
  end

  logic        d3_vld;
  logic [47:0] d3_mag;

  tch_delay #(.W(48), .DEPTH(N)) u_d3 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (d2_vld), .data_i (d2_side[47:0]),
    .valid_o (d3_vld), .data_o (d3_mag)
  );

  // ---------------- horizontal projection ----------------
  logic                 q_vld_q, t_vld_q, m_vld_q, h_vld_q, p_vld_q, c_vld_q, done_q;
  logic signed [15:0]   cp_q, sp_q, cr_q, sr_q;
  logic [47:0]          q_mag_q, t_mag_q;
  logic signed [15:0]   t_cp_q, t_sp_q, t_cr_q;
  logic signed [31:0]   srsp, cpsr;
  logic signed [16:0]   tt_q, uu_q;
  logic signed [15:0]   mx, my, mz;
  logic signed [31:0]   p1_q, p4_q, p5_q;
  logic signed [32:0]   p2_q, p3_q;
  logic signed [HW-1:0] hy_q, hx_q;

  assign srsp = sr_q * sp_q;
  assign cpsr = cp_q * sr_q;
  assign mx   = t_mag_q[47:32];
  assign my   = t_mag_q[31:16];
  assign mz   = t_mag_q[15:0];

  always_ff @(posedge clk_i) begin
    cp_q    <= q15_sat(cpx[N]);
    sp_q    <= q15_sat(cpy[N]);
    cr_q    <= q15_sat(crx[N]);
    sr_q    <= q15_sat(cry[N]);
    q_mag_q <= d3_mag;

    tt_q    <= 17'((srsp + 32'sd16384) >>> 15);
    uu_q    <= 17'((cpsr + 32'sd16384) >>> 15);
    t_cp_q  <= cp_q;
    t_sp_q  <= sp_q;
    t_cr_q  <= cr_q;
    t_mag_q <= q_mag_q;

    p1_q <= my * t_cr_q;
    p2_q <= 33'(mx) * 33'(tt_q);
    p3_q <= 33'(mz) * 33'(uu_q);
    p4_q <= mx * t_cp_q;
    p5_q <= mz * t_sp_q;

    hy_q <= HW'(p1_q) + HW'(p2_q) - HW'(p3_q);
    hx_q <= HW'(p4_q) + HW'(p5_q);
  end

  // ---------------- heading vectoring ----------------
  logic signed [HW-1:0]    hx0_q, hy0_q;
  logic signed [ANG_W-1:0] hz0_q;
  logic                    hzero_q;
  logic signed [HW-1:0]    hvx [N+1];
  logic signed [HW-1:0]    hvy [N+1];
  logic signed [ANG_W-1:0] hvz [N+1];

  // turn a left-half-plane vector by 90 degrees first
  always_ff @(posedge clk_i) begin
    hzero_q <= (hx_q == '0) && (hy_q == '0);
    if (hx_q[HW-1]) begin
      if (!hy_q[HW-1]) begin
        hx0_q <= hy_q;
        hy0_q <= -hx_q;
        hz0_q <= ANG_W'(16384);
      end else begin
        hx0_q <= -hy_q;
        hy0_q <= hx_q;
        hz0_q <= -ANG_W'(16384);
      end
    end else begin
      hx0_q <= hx_q;
      hy0_q <= hy_q;
      hz0_q <= '0;
    end
  end

  assign hvx[0] = hx0_q;
  assign hvy[0] = hy0_q;
  assign hvz[0] = hz0_q;

  for (genvar i = 0; i < N; i++) begin : g_vec_h
    tch_vec_cell #(.W(HW), .I(i)) u_h (
      .clk_i (clk_i),
      .x_i (hvx[i]), .y_i (hvy[i]), .z_i (hvz[i]),
      .x_o (hvx[i+1]), .y_o (hvy[i+1]), .z_o (hvz[i+1])
    );
  end

  logic d4_vld;
  logic d4_zero;

  tch_delay #(.W(1), .DEPTH(N)) u_d4 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (p_vld_q), .data_i (hzero_q),
    .valid_o (d4_vld), .data_o (d4_zero)
  );

  // ---------------- scale to centidegrees ----------------
  logic signed [ANG_W-1:0] ang;
  logic signed [34:0]      cdp_q;
  logic signed [34:0]      cdr;
  logic signed [15:0]      heading_q;

  assign ang = d4_zero ? '0 : hvz[N];
  assign cdr = (cdp_q + 35'sd32768) >>> 16;

  always_ff @(posedge clk_i) begin
    cdp_q <= ang * $signed(17'd36000);
    if (cdr > 35'sd18000)       heading_q <= 16'sd18000;
    else if (cdr < -35'sd18000) heading_q <= -16'sd18000;
    else                        heading_q <= cdr[15:0];
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      pre_vld_q <= 1'b0;
      q_vld_q   <= 1'b0;
      t_vld_q   <= 1'b0;
      m_vld_q   <= 1'b0;
      h_vld_q   <= 1'b0;
      p_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      s1_vld_q  <= start && !busy;
      pre_vld_q <= d1_vld;
      q_vld_q   <= d3_vld;
      t_vld_q   <= q_vld_q;
      m_vld_q   <= t_vld_q;
      h_vld_q   <= m_vld_q;
      p_vld_q   <= h_vld_q;
      c_vld_q   <= d4_vld;
      done_q    <= c_vld_q;
    end
  end

  assign done_o             = done_q;
  assign heading_centideg_o = heading_q;

endmodule

// ----- sv/tch_isqrt_cell.sv -----
// One bit of a pipelined floor integer square root: tests and sets root bit K.
// Depends on tch_pkg.
module tch_isqrt_cell import tch_pkg::*; #(
  parameter int K = 0
) (
  input  logic            clk_i,
  input  logic [SQ_W-1:0] rem_i,
  input  logic [RT_W-1:0] root_i,
  output logic [SQ_W-1:0] rem_o,
  output logic [RT_W-1:0] root_o
);

  logic [SQ_W:0]   trial;
  logic [SQ_W-1:0] rem_d, rem_q;
  logic [RT_W-1:0] root_d, root_q;

  always_comb begin
    // (root + 2^K)^2 - root^2
    trial = ((SQ_W+1)'(root_i) << (K + 1)) | ((SQ_W+1)'(1) << (2 * K));
    rem_d  = rem_i;
    root_d = root_i;
    if ({1'b0, rem_i} >= trial) begin
      rem_d  = rem_i - trial[SQ_W-1:0];
      root_d = root_i | (RT_W'(1) << K);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ----- sv/tch_vec_cell.sv -----
// One vectoring CORDIC stage: rotates toward y = 0 and accumulates the angle.
// Depends on tch_pkg for the arctangent table.
module tch_vec_cell import tch_pkg::*; #(
  parameter int W = 34,
  parameter int I = 0
) (
  input  logic                    clk_i,
  input  logic signed [W-1:0]     x_i,
  input  logic signed [W-1:0]     y_i,
  input  logic signed [ANG_W-1:0] z_i,
  output logic signed [W-1:0]     x_o,
  output logic signed [W-1:0]     y_o,
  output logic signed [ANG_W-1:0] z_o
);

  logic signed [W-1:0]     dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ANG_W-1:0] z_d, z_q;

  always_comb begin
    dx = y_i >>> I;
    dy = x_i >>> I;
    if (!y_i[W-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_tab(I);
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_tab(I);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ----- sv/tch_rot_cell.sv -----
// One rotation CORDIC stage: turns (x, y) by the table angle toward z = 0.
// Depends on tch_pkg for the arctangent table.
module tch_rot_cell import tch_pkg::*; #(
  parameter int W = 34,
  parameter int I = 0
) (
  input  logic                    clk_i,
  input  logic signed [W-1:0]     x_i,
  input  logic signed [W-1:0]     y_i,
  input  logic signed [ANG_W-1:0] z_i,
  output logic signed [W-1:0]     x_o,
  output logic signed [W-1:0]     y_o,
  output logic signed [ANG_W-1:0] z_o
);

  logic signed [W-1:0]     dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ANG_W-1:0] z_d, z_q;

  always_comb begin
    dx = y_i >>> I;
    dy = x_i >>> I;
    if (!z_i[ANG_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_tab(I);
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_tab(I);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ----- sv/tch_delay.sv -----
// Sideband delay line that keeps valid and pass-along data level with a cell chain.
// No package dependency.
module tch_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic         vld_q [DEPTH];
  logic [W-1:0] dat_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < DEPTH; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q[0] <= data_i;
    for (int i = 1; i < DEPTH; i++) dat_q[i] <= dat_q[i-1];
  end

  assign valid_o = vld_q[DEPTH-1];
  assign data_o  = dat_q[DEPTH-1];

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the tilt-compensated heading pipeline.
// Predicts each heading with a local integer CORDIC model; depends on tch_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import tch_pkg::*;

  localparam int STAGES    = 16;
  localparam int LATENCY   = 3 * STAGES + 24;
  localparam int MAX_CYCLE = 400000;
  localparam longint GAIN_Q30 = 64'sd652032874;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic signed [15:0] mag_x_i = '0, mag_y_i = '0, mag_z_i = '0;
  logic               done_o;
  logic signed [15:0] heading_centideg_o;

  logic signed [15:0] heading_q[$];
  int                 mismatch_cnt = 0;
  int                 cycle_cnt = 0;

  tilt_compensated_heading_top #(.CORDIC_STAGES(STAGES)) i_dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("status: fail");
      $finish;
    end
  end

  // Local angle table, atan(2^-i) in 1/65536 turn.
  function automatic longint atan_step(int i);
    longint t[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                      41, 20, 10, 5, 3, 1, 1, 0};
    return (i < 16) ? t[i] : 0;
  endfunction

  function automatic longint isqrt(longint n);
    longint root, bit_v;
    root = 0;
    bit_v = 64'sd1 << 62;
    while (bit_v > n) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n = n - (root + bit_v);
        root = (root >>> 1) + bit_v;
      end else begin
        root = root >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return root;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 16384;
      end else begin
        x = -y; y = t; z = -16384;
      end
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint to_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = GAIN_Q30; y = 0; z = ang;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = to_q15(x);
    s = to_q15(y);
  endfunction

  function automatic logic signed [15:0] predict_heading(
      longint ax, longint ay, longint az, longint mx, longint my, longint mz);
    longint dp, dr, pitch, roll, cp, sp, cr, sr, t, u, hy, hx, cd;
    dp = isqrt(ay * ay + az * az);
    dr = isqrt(ax * ax + az * az);
    pitch = angle_of(ax * 16384, dp * 16384);
    roll = angle_of(ay * 16384, dr * 16384);
    sin_cos(pitch, cp, sp);
    sin_cos(roll, cr, sr);
    t = (sr * sp + 16384) >>> 15;
    u = (cp * sr + 16384) >>> 15;
    hy = my * cr + mx * t - mz * u;
    hx = mx * cp + mz * sp;
    cd = (angle_of(hy, hx) * 36000 + 32768) >>> 16;
    if (cd > 18000) cd = 18000;
    if (cd < -18000) cd = -18000;
    return cd[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("mismatch @%0d: %s", cycle_cnt, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (heading_q.size() == 0) begin
        report_mismatch("heading with no transaction pending");
      end else begin
        if (heading_centideg_o !== heading_q[0])
          report_mismatch($sformatf("heading got %0d want %0d",
                                    heading_centideg_o, heading_q[0]));
        void'(heading_q.pop_front());
      end
    end
  end

  // Send one sample set; gap is the number of idle cycles before it.
  task automatic send_sample(input logic signed [15:0] ax, ay, az, mx, my, mz,
                             input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    accel_x_i <= ax; accel_y_i <= ay; accel_z_i <= az;
    mag_x_i <= mx; mag_y_i <= my; mag_z_i <= mz;
    do @(posedge clk_i); while (busy);
    heading_q.push_back(predict_heading(ax, ay, az, mx, my, mz));
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_corner_vectors();
    logic signed [15:0] ext[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    send_sample(0, 0, 0, 0, 0, 0, 0);            // zero everywhere
    send_sample(0, 0, 16384, 1000, 0, 0, 0);     // level, north
    send_sample(0, 0, 16384, -1000, 0, 0, 0);    // level, due south
    send_sample(0, 0, 16384, 0, 1000, 0, 0);
    send_sample(0, 0, 16384, 0, -1000, 0, 0);
    send_sample(0, 0, 0, 500, 300, -200, 0);     // zero accel, magnet only
    for (int i = 0; i < 16; i++)
      send_sample(ext[i % 4], ext[(i / 4) % 4], ext[i % 3], ext[(i + 1) % 4],
                  ext[(i + 2) % 4], ext[i / 4], 0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
  endtask

  task automatic test_random_samples(input int count);
    int gap;
    for (int n = 0; n < count; n++) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      send_sample(rand_axis(), rand_axis(), rand_axis(),
                  rand_axis(), rand_axis(), rand_axis(), gap);
    end
  endtask

  task automatic test_drain_then_resume();
    // hold off until the pipeline has emptied
    start <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
    test_random_samples(100);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_vectors();
    test_random_samples(550);
    test_drain_then_resume();
    test_random_samples(550);
    start <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tch_pkg.sv
sv/tch_isqrt_cell.sv
sv/tch_vec_cell.sv
sv/tch_rot_cell.sv
sv/tch_delay.sv
sv/tilt_compensated_heading_top.sv
test/tb_top.sv
